FILE: sv/gnss_binary_frame_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the GNSS binary frame parser
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GNSS_BINARY_FRAME_PARSER_UNIT_ASSERT_SVH
`define GNSS_BINARY_FRAME_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define GBFP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds while reset is asserted.
`define GBFP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBFP_ASSERT(label, clk, rst_n, prop, msg)
`define GBFP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: sv/gbfp_pkg.sv
// ----------------------------------------------------------------------------
// gbfp_pkg
// Types and constants shared by the GNSS binary frame parser modules.
// ----------------------------------------------------------------------------
package gbfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [7:0] CLASS_NAV   = 8'h01;
	localparam logic [7:0] CLASS_ACK   = 8'h05;
	localparam logic [7:0] CLASS_CFG   = 8'h06;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_ACCEPT  = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;

	localparam logic [15:0] MAX_LEN_RESET = 16'd256;

	localparam int TDATA_W = 56;
	localparam int TUSER_W = 2;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_SYNC2,
		ST_CLASS,
		ST_ID,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_PAYLOAD,
		ST_CK_A,
		ST_CK_B
	} state_t;

	typedef struct packed {
		logic [15:0] length;
		logic [7:0]  id;
		logic [7:0]  cls;
		logic [15:0] index;
		logic [7:0]  data;
		logic [1:0]  kind;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} result_msg_t;

endpackage

FILE: sv/gnss_binary_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_unit
// Binary GNSS frame recognizer with Fletcher-8 check, byte stream in and
// payload/status words out.
// ----------------------------------------------------------------------------
// A byte passes the input register and then the result register before its result word shows on m_*.
// Throughput: one byte per cycle; a word waiting on m_tready holds the result
// register, and the input register takes one more byte before s_tready drops.
// Reset: arst_n clears the parser to hunting for sync, the sums and header
// fields to zero, and max_payload_length to 256.
`include "gnss_binary_frame_parser_unit_assert.svh"

module gnss_binary_frame_parser_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,     // rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// payload_byte, payload_index, frame_class, frame_id, frame_length
	output logic [gbfp_pkg::TDATA_W-1:0] m_tdata,
	output logic [gbfp_pkg::TUSER_W-1:0] m_tuser,     // result_kind
	input  logic                         cfg_wr_en,
	input  logic [15:0]                  cfg_wr_data  // max_payload_length
);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  can_take;
	logic                  advance;
	logic [15:0]           max_len_q;
	gbfp_pkg::result_msg_t msg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= gbfp_pkg::MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// The byte in the input register is consumed whenever the result register can load.
	assign advance = valid_s1 && can_take;

	gbfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	gbfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.rx_byte (data_s1),
		.max_len (max_len_q),
		.msg     (msg)
	);

	gbfp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.msg      (msg),
		.can_take (can_take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`GBFP_ASSERT(a_stall_cause, clk, arst_n, !s_tready |-> (valid_s1 && m_tvalid && !m_tready), "input stalled without a blocked result word")

endmodule

FILE: sv/gbfp_in_stage.sv
// ----------------------------------------------------------------------------
// gbfp_in_stage
// Input register for received bytes; frees itself whenever its word moves on.
// ----------------------------------------------------------------------------
module gbfp_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // rx_byte
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] data_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

endmodule

FILE: sv/gbfp_parse.sv
// ----------------------------------------------------------------------------
// gbfp_parse
// Frame state machine, header registers and Fletcher-8 sums.
// ----------------------------------------------------------------------------
`include "gnss_binary_frame_parser_unit_assert.svh"

module gbfp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          max_len,
	output gbfp_pkg::result_msg_t msg
);

	gbfp_pkg::state_t state_q, state_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] idx_q, idx_d;
	logic [7:0]  add_a;
	logic [7:0]  add_b;

	assign add_a = sum_a_q + rx_byte;
	assign add_b = sum_b_q + add_a;

	always_comb begin
		state_d = state_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		class_d = class_q;
		id_d    = id_q;
		len_d   = len_q;
		idx_d   = idx_q;
		msg.valid      = 1'b0;
		msg.res.kind   = gbfp_pkg::KIND_PAYLOAD;
		msg.res.data   = 8'h00;
		msg.res.index  = 16'h0000;
		msg.res.cls    = class_q;
		msg.res.id     = id_q;
		msg.res.length = len_q;
		case (state_q)
			gbfp_pkg::ST_HUNT: begin
				sum_a_d = 8'h00;
				sum_b_d = 8'h00;
				state_d = (rx_byte == gbfp_pkg::SYNC_FIRST) ? gbfp_pkg::ST_SYNC2
					: gbfp_pkg::ST_HUNT;
			end
			gbfp_pkg::ST_SYNC2: begin
				if (rx_byte == gbfp_pkg::SYNC_FIRST) begin
					// A repeated first sync byte restarts the hunt in place.
					sum_a_d = 8'h00;
					sum_b_d = 8'h00;
				end else if (rx_byte == gbfp_pkg::SYNC_SECOND) begin
					state_d = gbfp_pkg::ST_CLASS;
				end else begin
					state_d = gbfp_pkg::ST_HUNT;
				end
			end
			gbfp_pkg::ST_CLASS: begin
				if (rx_byte inside {gbfp_pkg::CLASS_NAV, gbfp_pkg::CLASS_ACK,
						gbfp_pkg::CLASS_CFG}) begin
					class_d = rx_byte;
					sum_a_d = add_a;
					sum_b_d = add_b;
					state_d = gbfp_pkg::ST_ID;
				end else begin
					state_d = gbfp_pkg::ST_HUNT;
				end
			end
			gbfp_pkg::ST_ID: begin
				id_d    = rx_byte;
				sum_a_d = add_a;
				sum_b_d = add_b;
				state_d = gbfp_pkg::ST_LEN_LO;
			end
			gbfp_pkg::ST_LEN_LO: begin
				len_d   = {8'h00, rx_byte};
				sum_a_d = add_a;
				sum_b_d = add_b;
				state_d = gbfp_pkg::ST_LEN_HI;
			end
			gbfp_pkg::ST_LEN_HI: begin
				len_d = {rx_byte, len_q[7:0]};
				idx_d = 16'h0000;
				if (len_d > max_len) begin
					state_d = gbfp_pkg::ST_HUNT;
				end else begin
					sum_a_d = add_a;
					sum_b_d = add_b;
					state_d = (len_d == 16'h0000) ? gbfp_pkg::ST_CK_A
						: gbfp_pkg::ST_PAYLOAD;
				end
			end
			gbfp_pkg::ST_PAYLOAD: begin
				sum_a_d       = add_a;
				sum_b_d       = add_b;
				idx_d         = idx_q + 16'd1;
				msg.valid     = 1'b1;
				msg.res.data  = rx_byte;
				msg.res.index = idx_q;
				if (idx_q == len_q - 16'd1) begin
					state_d = gbfp_pkg::ST_CK_A;
				end
			end
			gbfp_pkg::ST_CK_A: begin
				if (sum_a_q != rx_byte) begin
					// The CK_B byte that follows is then treated as a hunting byte.
					msg.valid    = 1'b1;
					msg.res.kind = gbfp_pkg::KIND_REJECT;
					state_d      = gbfp_pkg::ST_HUNT;
				end else begin
					state_d = gbfp_pkg::ST_CK_B;
				end
			end
			gbfp_pkg::ST_CK_B: begin
				msg.valid    = 1'b1;
				msg.res.kind = (sum_b_q == rx_byte) ? gbfp_pkg::KIND_ACCEPT
					: gbfp_pkg::KIND_REJECT;
				state_d      = gbfp_pkg::ST_HUNT;
			end
			default: begin
				state_d = gbfp_pkg::ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbfp_pkg::ST_HUNT;
			sum_a_q <= 8'h00;
			sum_b_q <= 8'h00;
			class_q <= 8'h00;
			id_q    <= 8'h00;
			len_q   <= 16'h0000;
			idx_q   <= 16'h0000;
		end else if (fire) begin
			state_q <= state_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			class_q <= class_d;
			id_q    <= id_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
		end
	end

	`GBFP_ASSERT_ALWAYS(a_idx_in_frame, clk, (state_q == gbfp_pkg::ST_PAYLOAD) |-> (idx_q < len_q), "payload index ran past the declared length")
	`GBFP_ASSERT(a_ckb_ends_frame, clk, arst_n, (fire && state_q == gbfp_pkg::ST_CK_B) |=> (state_q == gbfp_pkg::ST_HUNT), "parser did not return to hunting after CK_B")
	`GBFP_ASSERT(a_len_limit, clk, arst_n, (fire && state_q == gbfp_pkg::ST_LEN_HI && state_d == gbfp_pkg::ST_PAYLOAD) |-> (len_d <= max_len), "over-length frame entered the payload")

endmodule

FILE: sv/gbfp_out_stage.sv
// ----------------------------------------------------------------------------
// gbfp_out_stage
// Result register that drives the master-side stream.
// ----------------------------------------------------------------------------
`include "gnss_binary_frame_parser_unit_assert.svh"

module gbfp_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  gbfp_pkg::result_msg_t         msg,
	output logic                          can_take,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// payload_byte, payload_index, frame_class, frame_id, frame_length
	output logic [gbfp_pkg::TDATA_W-1:0]  m_tdata,
	// result_kind
	output logic [gbfp_pkg::TUSER_W-1:0]  m_tuser
);

	gbfp_pkg::result_t res_s2;

	assign can_take = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (can_take) begin
			m_tvalid <= valid_s1 && msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && valid_s1 && msg.valid) begin
			res_s2 <= msg.res;
		end
	end

	assign m_tdata = {res_s2.length, res_s2.id, res_s2.cls, res_s2.index, res_s2.data};
	assign m_tuser = res_s2.kind;

	`GBFP_ASSERT(a_status_no_data, clk, arst_n, (m_tvalid && m_tuser != gbfp_pkg::KIND_PAYLOAD) |-> (m_tdata[23:0] == 24'h000000), "status word carries payload data")

endmodule
